>>> hdl/wbs_pkg.sv
package wbs_pkg;

    localparam int PAT_BYTES_DEFAULT = 128;

    typedef enum logic [1:0] {
        REQ_TEXT     = 2'd0,
        REQ_END      = 2'd1,
        REQ_CODE     = 2'd2,
        REQ_SCAN_END = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_COMPILE = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_NOMATCH = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_HEX  = 3'd1,
        ST_DANGLING = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_AFTER_Q = 2'd1,
        PH_HIGH    = 2'd2,
        PH_IDLE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic take;
        logic scan_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic item_result;
        logic item_scan;
        logic scan_done;
        logic scan_match;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/wbs_if.sv
interface wbs_req_if import wbs_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  text_char;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        region_start;

    modport source (
        output valid, req_type, text_char, data_byte, byte_address, region_start,
        input  ready
    );
    modport sink (
        input  valid, req_type, text_char, data_byte, byte_address, region_start,
        output ready
    );
endinterface

interface wbs_res_if import wbs_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [31:0] match_address;
    logic [7:0]  pattern_length;

    modport source (
        output valid, result_kind, status, match_address, pattern_length,
        input  ready
    );
    modport sink (
        input  valid, result_kind, status, match_address, pattern_length,
        output ready
    );
endinterface

>>> hdl/wildcard_byte_signature_scanner.sv
// Byte signature scanner with per-byte wildcards.
// Requests arrive on i_req (valid/ready); each carries a type: a signature text
// character, a pattern end, a code byte with its address, or a scan end.
// Results leave on o_res through an output register, so the block keeps taking
// requests while a result waits for the receiver.
// Text characters and code bytes that leave no full window keep the input ready.
// A pattern end, or a scan end after no match, loads its result through the emit state.
// A code byte that completes a window walks the pattern against the window, one
// position a cycle through the registered read ports of the pattern and window
// memories: the walk keeps the input closed until the last position compares or a
// mismatch ends it early, and a match then loads the output register via the emit state.
// When the receiver stalls, a pending result holds the block before its next
// request; the output register keeps its contents until taken.
// Reset clears the parser, the window fill and the output valid; the stores
// need no clearing pass and nothing is ready to match until a pattern compiles.
module wildcard_byte_signature_scanner import wbs_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = PAT_BYTES_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wbs_req_if.sink   i_req,
    wbs_res_if.source o_res
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    wbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wbs_datapath #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req.req_type),
        .i_text_char      (i_req.text_char),
        .i_data_byte      (i_req.data_byte),
        .i_byte_address   (i_req.byte_address),
        .i_region_start   (i_req.region_start),
        .i_res_ready      (o_res.ready),
        .o_res_valid      (o_res.valid),
        .o_result_kind    (o_res.result_kind),
        .o_status         (o_res.status),
        .o_match_address  (o_res.match_address),
        .o_pattern_length (o_res.pattern_length)
    );

    assign i_req.ready = in_ready;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output register loaded while still occupied");

    a_match_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.scan_match |=> !i_req.ready)
        else $error("request taken before a match result was delivered");

    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !cmd.take && !i_req.ready)
        else $error("request taken during a window compare");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.result_kind == KIND_COMPILE
                      || o_res.result_kind == KIND_MATCH
                      || o_res.result_kind == KIND_NOMATCH))
        else $error("illegal result kind on output");

endmodule

>>> hdl/wbs_ctrl.sv
module wbs_ctrl import wbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.item_scan) begin
                        n_state = S_SCAN;
                    end else if (i_stat.item_result) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_match) begin
                    n_state = S_EMIT;
                end else if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/wbs_datapath.sv
module wbs_datapath import wbs_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = PAT_BYTES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_text_char,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_byte_address,
    input  logic        i_region_start,
    input  logic        i_res_ready,
    output logic        o_res_valid,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_status,
    output logic [31:0] o_match_address,
    output logic [7:0]  o_pattern_length
);

    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int PW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [LW-1:0] MAX_L  = LW'(MAX_PATTERN_BYTES);
    localparam logic [PW-1:0] LAST_P = PW'(MAX_PATTERN_BYTES - 1);

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // bit 4 flags a valid hex digit, bits 3:0 carry its value
    function automatic logic [4:0] nib_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[CH_0:CH_9]}) begin
            v = c - CH_0;
            return {1'b1, v[3:0]};
        end
        if (c inside {[CH_UA:CH_UF]}) begin
            v = c - CH_UA + HEX_TEN;
            return {1'b1, v[3:0]};
        end
        if (c inside {[CH_LA:CH_LF_HEX]}) begin
            v = c - CH_LA + HEX_TEN;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    // pattern entries carry the wildcard mark in bit 8
    logic [8:0] mem_pat [MAX_PATTERN_BYTES];
    logic [7:0] mem_win [MAX_PATTERN_BYTES];

    logic [LW-1:0] r_len,   n_len;
    t_phase        r_phase, n_phase;
    logic [3:0]    r_hi,    n_hi;
    t_status       r_err,   n_err;
    logic          r_rdy,   n_rdy;
    logic [LW-1:0] r_fill,  n_fill;
    logic          r_found, n_found;
    logic [PW-1:0] r_wptr,  n_wptr;
    logic [LW-1:0] r_issue, n_issue;
    logic [LW-1:0] r_chk,   n_chk;
    logic          r_qv,    n_qv;
    logic          r_o_valid, n_o_valid;

    logic [PW-1:0] r_pidx,   n_pidx;
    logic [PW-1:0] r_widx,   n_widx;
    logic [31:0]   r_mstart, n_mstart;
    logic [8:0]    r_pat_q;
    logic [7:0]    r_win_q;
    t_kind         r_res_kind,   n_res_kind;
    t_status       r_res_status, n_res_status;
    logic [31:0]   r_res_addr,   n_res_addr;
    logic [7:0]    r_res_len,    n_res_len;
    t_kind         r_o_kind;
    t_status       r_o_status;
    logic [31:0]   r_o_addr;
    logic [7:0]    r_o_len;

    t_req_type     w_req;
    logic [4:0]    w_nib;
    logic          w_skip;
    logic          w_put;
    logic [8:0]    w_put_data;
    logic          w_pat_we;
    logic [PW-1:0] w_pat_wa;
    logic          w_win_we;
    t_status       w_end_st;
    logic [7:0]    w_rlen;
    logic [LW-1:0] w_fill_base;
    logic [LW-1:0] w_fill_new;
    logic [PW-1:0] w_wptr_nx;
    logic [LW:0]   w_wx;
    logic [LW:0]   w_lx;
    logic [LW:0]   w_start;
    logic          w_code_live;
    logic          w_cmp_ok;
    logic          w_cmp_last;

    assign w_req       = t_req_type'(i_req_type);
    assign w_nib       = nib_of(i_text_char);
    assign w_rlen      = r_rdy ? 8'(r_len) : 8'd0;
    assign w_fill_base = i_region_start ? '0 : r_fill;
    assign w_fill_new  = (w_fill_base < MAX_L) ? w_fill_base + 1'b1 : w_fill_base;
    assign w_wptr_nx   = (r_wptr == LAST_P) ? '0 : r_wptr + 1'b1;
    assign w_code_live = r_rdy && !r_found;
    assign w_wx        = (LW+1)'(w_wptr_nx);
    assign w_lx        = (LW+1)'(r_len);
    // oldest byte of the window, wrapped round the circular buffer
    assign w_start     = (w_wx >= w_lx) ? w_wx - w_lx
                                        : w_wx + (LW+1)'(MAX_PATTERN_BYTES) - w_lx;
    assign w_cmp_ok    = r_pat_q[8] || (r_pat_q[7:0] == r_win_q);
    assign w_cmp_last  = (r_chk == LW'(1));

    assign o_stat.item_result = (w_req == REQ_END) || ((w_req == REQ_SCAN_END) && !r_found);
    assign o_stat.item_scan   = (w_req == REQ_CODE) && w_code_live && (w_fill_new >= r_len);
    assign o_stat.scan_done   = i_cmd.scan_step && r_qv && (!w_cmp_ok || w_cmp_last);
    assign o_stat.scan_match  = i_cmd.scan_step && r_qv && w_cmp_ok && w_cmp_last;
    assign o_stat.out_free    = !r_o_valid || i_res_ready;

    always_comb begin
        n_len        = r_len;
        n_phase      = r_phase;
        n_hi         = r_hi;
        n_err        = r_err;
        n_rdy        = r_rdy;
        n_fill       = r_fill;
        n_found      = r_found;
        n_wptr       = r_wptr;
        n_issue      = r_issue;
        n_chk        = r_chk;
        n_qv         = 1'b0;
        n_pidx       = r_pidx;
        n_widx       = r_widx;
        n_mstart     = r_mstart;
        n_res_kind   = r_res_kind;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_len    = r_res_len;
        w_skip       = 1'b0;
        w_put        = 1'b0;
        w_put_data   = '0;
        w_pat_we     = 1'b0;
        w_pat_wa     = '0;
        w_win_we     = 1'b0;
        w_end_st     = ST_OK;

        if (i_cmd.take) begin
            case (w_req)
                REQ_TEXT: begin
                    n_rdy   = 1'b0;
                    n_found = 1'b0;
                    n_fill  = '0;
                    // first character after a pattern end opens a new compile
                    if (r_phase == PH_IDLE) begin
                        n_len   = '0;
                        n_err   = ST_OK;
                        n_hi    = '0;
                        n_phase = PH_BETWEEN;
                    end
                    if (n_err == ST_OK) begin
                        if (n_phase == PH_HIGH) begin
                            n_phase = PH_BETWEEN;
                            if (!w_nib[4]) begin
                                n_err = ST_BAD_HEX;
                            end else begin
                                w_put      = 1'b1;
                                w_put_data = {1'b0, n_hi, w_nib[3:0]};
                                n_hi       = '0;
                            end
                        end else begin
                            if (n_phase == PH_AFTER_Q) begin
                                n_phase = PH_BETWEEN;
                                w_skip  = (i_text_char == CH_QMARK);
                            end
                            if (!w_skip && !is_sep(i_text_char)) begin
                                if (i_text_char == CH_QMARK) begin
                                    w_put      = 1'b1;
                                    w_put_data = {1'b1, 8'd0};
                                    n_phase    = PH_AFTER_Q;
                                end else if (!w_nib[4]) begin
                                    n_err = ST_BAD_HEX;
                                end else begin
                                    n_hi    = w_nib[3:0];
                                    n_phase = PH_HIGH;
                                end
                            end
                        end
                    end
                    if (w_put) begin
                        if (n_len >= MAX_L) begin
                            n_err = ST_TOO_LONG;
                        end else begin
                            w_pat_we = 1'b1;
                            w_pat_wa = PW'(n_len);
                            n_len    = n_len + 1'b1;
                        end
                    end
                end
                REQ_END: begin
                    if (r_phase == PH_IDLE) begin
                        n_len = '0;
                        n_err = ST_OK;
                    end
                    if (n_err != ST_OK) begin
                        w_end_st = n_err;
                    end else if (r_phase == PH_HIGH) begin
                        w_end_st = ST_DANGLING;
                    end else if (n_len == '0) begin
                        w_end_st = ST_EMPTY;
                    end else begin
                        w_end_st = ST_OK;
                    end
                    n_rdy        = (w_end_st == ST_OK);
                    n_phase      = PH_IDLE;
                    n_hi         = '0;
                    n_err        = ST_OK;
                    n_found      = 1'b0;
                    n_fill       = '0;
                    n_res_kind   = KIND_COMPILE;
                    n_res_status = w_end_st;
                    n_res_addr   = '0;
                    n_res_len    = (w_end_st == ST_OK) ? 8'(n_len) : 8'd0;
                end
                REQ_CODE: begin
                    if (w_code_live) begin
                        n_fill   = w_fill_new;
                        w_win_we = 1'b1;
                        n_wptr   = w_wptr_nx;
                        if (w_fill_new >= r_len) begin
                            n_pidx   = '0;
                            n_widx   = PW'(w_start);
                            n_issue  = r_len;
                            n_chk    = r_len;
                            n_mstart = i_byte_address - 32'(r_len) + 32'd1;
                        end
                    end
                end
                REQ_SCAN_END: begin
                    n_found = 1'b0;
                    n_fill  = '0;
                    if (!r_found) begin
                        n_res_kind   = KIND_NOMATCH;
                        n_res_status = ST_OK;
                        n_res_addr   = '0;
                        n_res_len    = w_rlen;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.scan_step) begin
            // issue reads one position ahead of the compare
            if (r_issue != '0) begin
                n_qv    = 1'b1;
                n_issue = r_issue - 1'b1;
                n_pidx  = (r_pidx == LAST_P) ? '0 : r_pidx + 1'b1;
                n_widx  = (r_widx == LAST_P) ? '0 : r_widx + 1'b1;
            end
            if (r_qv && w_cmp_ok) begin
                n_chk = r_chk - 1'b1;
                if (w_cmp_last) begin
                    n_found      = 1'b1;
                    n_res_kind   = KIND_MATCH;
                    n_res_status = ST_OK;
                    n_res_addr   = r_mstart;
                    n_res_len    = w_rlen;
                end
            end
        end

        if (i_cmd.load_out) begin
            n_o_valid = 1'b1;
        end else if (i_res_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_phase   <= PH_BETWEEN;
            r_hi      <= '0;
            r_err     <= ST_OK;
            r_rdy     <= 1'b0;
            r_fill    <= '0;
            r_found   <= 1'b0;
            r_wptr    <= '0;
            r_issue   <= '0;
            r_chk     <= '0;
            r_qv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_phase   <= n_phase;
            r_hi      <= n_hi;
            r_err     <= n_err;
            r_rdy     <= n_rdy;
            r_fill    <= n_fill;
            r_found   <= n_found;
            r_wptr    <= n_wptr;
            r_issue   <= n_issue;
            r_chk     <= n_chk;
            r_qv      <= n_qv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_widx       <= n_widx;
        r_mstart     <= n_mstart;
        r_res_kind   <= n_res_kind;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_len    <= n_res_len;
        if (i_cmd.load_out) begin
            r_o_kind   <= r_res_kind;
            r_o_status <= r_res_status;
            r_o_addr   <= r_res_addr;
            r_o_len    <= r_res_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            mem_pat[w_pat_wa] <= w_put_data;
        end
        if (w_win_we) begin
            mem_win[r_wptr] <= i_data_byte;
        end
        r_pat_q <= mem_pat[r_pidx];
        r_win_q <= mem_win[r_widx];
    end

    assign o_res_valid      = r_o_valid;
    assign o_result_kind    = r_o_kind;
    assign o_status         = r_o_status;
    assign o_match_address  = r_o_addr;
    assign o_pattern_length = r_o_len;

endmodule

>>> sim/scan_result_monitor.sv
`timescale 1ns / 1ps

module scan_result_monitor import wbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wbs_req_if   i_req,
    wbs_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending_count
);

    localparam int MAXP = PAT_BYTES_DEFAULT;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] address;
        logic [7:0]  length;
    } t_result;

    t_result     awaited_results [$];

    // compiled signature and the parser behind it
    logic [7:0]  sig_byte [MAXP];
    bit          sig_wild [MAXP];
    int unsigned sig_len;
    t_phase      parse_state;
    logic [3:0]  high_nibble;
    t_status     first_error;
    bit          sig_armed;

    // sliding window over the code stream, newest byte at the top
    logic [7:0]  code_window [MAXP];
    int unsigned window_fill;
    bit          hit_reported;

    int          fail_total;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c - CH_DIGIT0);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    task automatic store_byte(input logic [7:0] value, input bit wild);
        if (sig_len >= MAXP) begin
            first_error = ST_TOO_LONG;
        end else begin
            sig_byte[sig_len] = value;
            sig_wild[sig_len] = wild;
            sig_len++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result     want;
        t_result     fresh;
        t_status     st;
        logic [7:0]  held_len;
        logic [7:0]  c;
        int          nib;
        int          k;
        bit          hit;
        bit          had_hit;

        if (!i_rst_n) begin
            awaited_results.delete();
            sig_len      = 0;
            parse_state  = PH_BETWEEN;
            high_nibble  = '0;
            first_error  = ST_OK;
            sig_armed    = 1'b0;
            window_fill  = 0;
            hit_reported = 1'b0;
            fail_total   = 0;
            for (k = 0; k < MAXP; k++) begin
                code_window[k] = '0;
            end
        end else begin
            // compare before predicting: a result never leaves in its own request's cycle
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d %s %0d",
                             $time, i_res.result_kind, "status", i_res.status);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(i_res.result_kind));
                    check_field("status", 32'(want.status), 32'(i_res.status));
                    check_field("match_address", want.address, i_res.match_address);
                    check_field("pattern_length", 32'(want.length), 32'(i_res.pattern_length));
                end
            end

            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                held_len = sig_armed ? 8'(sig_len) : 8'd0;
                c = i_req.text_char;
                case (t_req_type'(i_req.req_type))
                    REQ_TEXT: begin
                        sig_armed    = 1'b0;
                        hit_reported = 1'b0;
                        window_fill  = 0;
                        if (parse_state == PH_IDLE) begin
                            sig_len     = 0;
                            first_error = ST_OK;
                            high_nibble = '0;
                            parse_state = PH_BETWEEN;
                        end
                        // after an error every character is dropped until the pattern end
                        if (first_error == ST_OK) begin
                            if (parse_state == PH_HIGH) begin
                                nib = hex_value(c);
                                parse_state = PH_BETWEEN;
                                if (nib < 0) begin
                                    first_error = ST_BAD_HEX;
                                end else begin
                                    store_byte({high_nibble, nib[3:0]}, 1'b0);
                                    high_nibble = '0;
                                end
                            end else if (parse_state == PH_AFTER_Q && c == CH_QMARK) begin
                                parse_state = PH_BETWEEN;
                            end else begin
                                parse_state = PH_BETWEEN;
                                if (c == CH_QMARK) begin
                                    store_byte(8'h00, 1'b1);
                                    parse_state = PH_AFTER_Q;
                                end else if (c != CH_SPACE && c != CH_TAB &&
                                             c != CH_CR && c != CH_NEWLINE) begin
                                    nib = hex_value(c);
                                    if (nib < 0) begin
                                        first_error = ST_BAD_HEX;
                                    end else begin
                                        high_nibble = nib[3:0];
                                        parse_state = PH_HIGH;
                                    end
                                end
                            end
                        end
                    end
                    REQ_END: begin
                        if (parse_state == PH_IDLE) begin
                            sig_len     = 0;
                            first_error = ST_OK;
                        end
                        if (first_error != ST_OK) begin
                            st = first_error;
                        end else if (parse_state == PH_HIGH) begin
                            st = ST_DANGLING;
                        end else if (sig_len == 0) begin
                            st = ST_EMPTY;
                        end else begin
                            st = ST_OK;
                        end
                        sig_armed    = (st == ST_OK);
                        parse_state  = PH_IDLE;
                        high_nibble  = '0;
                        first_error  = ST_OK;
                        hit_reported = 1'b0;
                        window_fill  = 0;
                        fresh = '{kind: KIND_COMPILE, status: st, address: 32'd0,
                                  length: (st == ST_OK) ? 8'(sig_len) : 8'd0};
                        awaited_results.push_back(fresh);
                    end
                    REQ_CODE: begin
                        if (sig_armed && !hit_reported) begin
                            if (i_req.region_start) window_fill = 0;
                            for (k = 0; k < MAXP - 1; k++) begin
                                code_window[k] = code_window[k + 1];
                            end
                            code_window[MAXP - 1] = i_req.data_byte;
                            if (window_fill < MAXP) window_fill++;
                            if (window_fill >= sig_len) begin
                                hit = 1'b1;
                                for (k = 0; k < sig_len; k++) begin
                                    if (!sig_wild[k] &&
                                        code_window[MAXP - sig_len + k] != sig_byte[k]) begin
                                        hit = 1'b0;
                                    end
                                end
                                if (hit) begin
                                    hit_reported = 1'b1;
                                    fresh = '{kind: KIND_MATCH, status: ST_OK,
                                              address: i_req.byte_address - 32'(sig_len - 1),
                                              length: held_len};
                                    awaited_results.push_back(fresh);
                                end
                            end
                        end
                    end
                    REQ_SCAN_END: begin
                        had_hit      = hit_reported;
                        hit_reported = 1'b0;
                        window_fill  = 0;
                        if (!had_hit) begin
                            fresh = '{kind: KIND_NOMATCH, status: ST_OK, address: 32'd0,
                                      length: held_len};
                            awaited_results.push_back(fresh);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count    = fail_total;
        o_pending_count = awaited_results.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import wbs_pkg::*;

    localparam int     MAXP         = PAT_BYTES_DEFAULT;
    localparam int     ITEM_TARGET  = 1150;
    localparam int     DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT  = 64'd2_000_000;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef enum int {
        FAULT_FIRST_DIGIT,
        FAULT_LOW_DIGIT,
        FAULT_DANGLING,
        FAULT_EMPTY
    } t_fault;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending_count;
    longint cycle_count   = 0;
    int     items_sent    = 0;
    bit     source_steady = 1'b0;
    bit     sink_steady   = 1'b0;
    int     stall_left    = 0;

    // signature under test; one spare entry so an overlong text can be built
    logic [7:0] pat_val  [MAXP + 1];
    bit         pat_wild [MAXP + 1];
    int         pat_len;

    wbs_req_if req_ch ();
    wbs_res_if res_ch ();

    wildcard_byte_signature_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    scan_result_monitor u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver side: short stalls mostly, a few long ones, and calm stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) sink_steady <= !sink_steady;
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (sink_steady || $urandom_range(0, 3) != 0) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= 1'b0;
            stall_left   <= gap_length() - 1;
        end
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10) return CH_DIGIT0 + 8'(n);
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n - 4'd10);
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= CH_DIGIT0 && c <= CH_DIGIT9) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F);
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NEWLINE;
        endcase
    endfunction

    task automatic send_request(input t_req_type kind, input logic [7:0] ch,
                                input logic [7:0] db, input logic [31:0] addr,
                                input logic rs);
        int gap;
        gap = 0;
        if ($urandom_range(0, 149) == 0) source_steady = !source_steady;
        if (!source_steady && $urandom_range(0, 3) == 0) gap = gap_length();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.text_char    <= ch;
        req_ch.data_byte    <= db;
        req_ch.byte_address <= addr;
        req_ch.region_start <= rs;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_text(input logic [7:0] c);
        send_request(REQ_TEXT, c, 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic send_control(input t_req_type kind);
        send_request(kind, 8'($urandom), 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic send_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_text(s[k]);
        end
    endtask

    task automatic send_code(input logic [7:0] b, input logic [31:0] addr, input logic rs);
        send_request(REQ_CODE, 8'($urandom), b, addr, rs);
    endtask

    // drop valid and hold until every awaited result has been taken
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic make_pattern(input int len);
        int k;
        int wild_pct;
        pat_len  = len;
        wild_pct = $urandom_range(0, 40);
        for (k = 0; k < len; k++) begin
            pat_val[k]  = 8'($urandom);
            pat_wild[k] = ($urandom_range(0, 99) < wild_pct);
        end
    endtask

    task automatic send_pattern_text();
        int k;
        int seps;
        bit lone_q;
        lone_q = 1'b0;
        for (k = 0; k < pat_len; k++) begin
            // keep full-size texts compact
            seps = (pat_len >= MAXP || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2);
            // a lone '?' would swallow a following '?': keep them apart
            if (lone_q && pat_wild[k] && seps == 0) seps = 1;
            repeat (seps) send_text(sep_char());
            if (pat_wild[k]) begin
                send_text(CH_QMARK);
                lone_q = $urandom_range(0, 1);
                if (!lone_q) send_text(CH_QMARK);
            end else begin
                send_text(hex_digit(pat_val[k][7:4]));
                send_text(hex_digit(pat_val[k][3:0]));
                lone_q = 1'b0;
            end
        end
        if ($urandom_range(0, 1)) send_text(sep_char());
    endtask

    task automatic run_good_flow(input int len);
        int          region_idx;
        int          nregions;
        int          rlen;
        int          off;
        int          i;
        bit          plant;
        bit          narrow;
        logic [31:0] base;
        logic [7:0]  b;
        make_pattern(len);
        send_pattern_text();
        send_control(REQ_END);
        repeat ($urandom_range(1, 2)) begin
            nregions = $urandom_range(1, 3);
            for (region_idx = 0; region_idx < nregions; region_idx++) begin
                rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, pat_len)
                                                   : pat_len + $urandom_range(0, 10);
                plant  = ($urandom_range(0, 2) != 0) && (rlen >= pat_len);
                off    = plant ? $urandom_range(0, rlen - pat_len) : 0;
                narrow = $urandom_range(0, 1);
                // some regions straddle the top of the address space
                base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, rlen)
                                                   : $urandom;
                for (i = 0; i < rlen; i++) begin
                    if (plant && i >= off && i < off + pat_len && !pat_wild[i - off]) begin
                        b = pat_val[i - off];
                    end else if (narrow) begin
                        b = pat_val[$urandom_range(0, pat_len - 1)];
                    end else begin
                        b = 8'($urandom);
                    end
                    send_code(b, base + i, (i == 0) ? ($urandom_range(0, 4) != 0) : 1'b0);
                end
            end
            send_control(REQ_SCAN_END);
        end
    endtask

    initial begin : stimulus
        int          r;
        int          len;
        int          k;
        t_fault      fault;
        logic [7:0]  c;

        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_TEXT;
        req_ch.text_char    <= 8'h00;
        req_ch.data_byte    <= 8'h00;
        req_ch.byte_address <= 32'h0;
        req_ch.region_start <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing compiled yet: code ignored, scan end reports no match
        send_code(8'h5A, 32'h0000_1000, 1'b1);
        send_control(REQ_SCAN_END);
        // empty text, then a pattern end straight after another
        send_control(REQ_END);
        send_control(REQ_END);
        // every separator, both wildcard forms, both letter cases
        send_string(" a5\t??\r?\n0F");
        send_control(REQ_END);
        // match wrapping through address zero, then a byte after the match
        send_code(8'hA5, 32'hFFFF_FFFE, 1'b1);
        send_code(8'h3C, 32'hFFFF_FFFF, 1'b0);
        send_code(8'h77, 32'h0000_0000, 1'b0);
        send_code(8'h0F, 32'h0000_0001, 1'b0);
        send_code(8'h0F, 32'h0000_0002, 1'b0);
        send_control(REQ_SCAN_END);
        send_control(REQ_SCAN_END);
        // bad first digit, bad low digit, dangling nibble
        send_string("G");
        send_control(REQ_END);
        send_string("A?");
        send_control(REQ_END);
        send_string("7");
        send_control(REQ_END);
        hold_until_drained();

        // full-size signature, then one token too many
        run_good_flow(MAXP);
        make_pattern(MAXP + 1);
        send_pattern_text();
        send_control(REQ_END);

        while (items_sent < ITEM_TARGET) begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            if (r < 60) begin
                run_good_flow(len);
            end else if (r < 78) begin
                make_pattern($urandom_range(1, 6));
                fault = t_fault'($urandom_range(0, 3));
                if (fault != FAULT_EMPTY) send_pattern_text();
                case (fault)
                    FAULT_FIRST_DIGIT: begin
                        do c = 8'($urandom);
                        while (is_hex(c) || c == CH_QMARK || c == CH_SPACE || c == CH_TAB ||
                               c == CH_CR || c == CH_NEWLINE);
                        send_text(c);
                    end
                    FAULT_LOW_DIGIT: begin
                        send_text(hex_digit(4'($urandom)));
                        if ($urandom_range(0, 1)) begin
                            send_text($urandom_range(0, 1) ? sep_char() : CH_QMARK);
                        end else begin
                            do c = 8'($urandom); while (is_hex(c));
                            send_text(c);
                        end
                    end
                    FAULT_DANGLING: begin
                        send_text(hex_digit(4'($urandom)));
                    end
                    default: begin
                        repeat ($urandom_range(0, 3)) send_text(sep_char());
                    end
                endcase
                // characters after an error are dropped
                if (fault == FAULT_FIRST_DIGIT || fault == FAULT_LOW_DIGIT) begin
                    repeat ($urandom_range(0, 3)) send_text(8'($urandom));
                end
                send_control(REQ_END);
                if ($urandom_range(0, 1)) send_control(REQ_END);
                for (k = 0; k < $urandom_range(0, 4); k++) begin
                    send_code(8'($urandom), $urandom, 1'($urandom));
                end
                send_control(REQ_SCAN_END);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 10)) begin
                    send_request(t_req_type'($urandom_range(0, 3)), 8'($urandom),
                                 8'($urandom), $urandom, 1'($urandom));
                end
            end else begin
                hold_until_drained();
                run_good_flow(len);
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
